/* rtl/core/kpst_pkg.sv */
// Shared types and codes of the keyed pointer slot table.
`default_nettype none

package kpst_pkg;

	// Operation codes of an input beat.
	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_PULL  = 2'd1,
		CMD_FIND  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture the input beat and read slot 0
		logic scan_step;   // advance the scan index and read the next slot
		logic scan_hit;    // record the current scan index as the match
		logic push_wr;     // write the pushed entry
		logic shift_begin; // start the compaction at the matching slot
		logic shift_wr;    // copy the fetched slot one place down
		logic shift_next;  // advance the compaction index and read ahead
		logic cnt_inc;
		logic cnt_dec;
		logic cnt_clr;
		logic drop;        // flag the push as dropped
		logic emit;        // register the result beat
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic count_zero;
		logic match;
		logic scan_last;
		logic hit;
		logic room;
		logic pull_tail;
		logic shift_last;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/core/kpst_ctrl.sv */
// Controller state machine of the keyed pointer slot table.
`default_nettype none

module kpst_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  kpst_pkg::sts_t     sts,
	output kpst_pkg::ctl_t     ctl,
	output logic               busy
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_EXEC  = 4'b0100,
		ST_SHIFT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					state_d  = sts.count_zero ? ST_EXEC : ST_SCAN;
				end
			end
			ST_SCAN: begin
				priority if (sts.match) begin
					ctl.scan_hit = 1'b1;
					state_d      = ST_EXEC;
				end else if (sts.scan_last) begin
					state_d = ST_EXEC;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				unique case (sts.cmd)
					kpst_pkg::CMD_PUSH: begin
						ctl.emit = 1'b1;
						if (sts.hit || sts.room) begin
							ctl.push_wr = 1'b1;
							ctl.cnt_inc = !sts.hit;
						end else begin
							ctl.drop = 1'b1;
						end
					end
					kpst_pkg::CMD_PULL: begin
						priority if (sts.hit && sts.pull_tail) begin
							ctl.shift_begin = 1'b1;
							state_d         = ST_SHIFT;
						end else if (sts.hit) begin
							ctl.cnt_dec = 1'b1;
							ctl.emit    = 1'b1;
						end else begin
							ctl.emit = 1'b1;
						end
					end
					kpst_pkg::CMD_FIND: begin
						ctl.emit = 1'b1;
					end
					kpst_pkg::CMD_CLEAR: begin
						ctl.cnt_clr = 1'b1;
						ctl.emit    = 1'b1;
					end
					default: begin
						ctl.emit = 1'b1;
					end
				endcase
			end
			ST_SHIFT: begin
				ctl.shift_wr = 1'b1;
				if (sts.shift_last) begin
					ctl.cnt_dec = 1'b1;
					ctl.emit    = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					ctl.shift_next = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/kpst_dpath.sv */
// Datapath of the keyed pointer slot table: slot memory, scan index and result registers.
`default_nettype none

module kpst_dpath #(
	parameter int DEPTH       = 16,
	parameter int COORD_WIDTH = 16,
	parameter int CNT_W       = $clog2(DEPTH + 1),
	parameter int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [1:0]          cmd,
	input  wire logic [31:0]         id,
	input  wire logic [31:0]         ref_tag,
	input  wire logic signed [15:0]  x_pos,
	input  wire logic signed [15:0]  y_pos,
	input  wire logic [4:0]          capacity,
	input  kpst_pkg::ctl_t           ctl,
	output kpst_pkg::sts_t           sts,
	output logic                     done,
	output logic                     found,
	output logic [IDX_W-1:0]         slot_index,
	output logic [CNT_W-1:0]         count,
	output logic                     dropped
);

	localparam int ENT_W = 64 + 2 * COORD_WIDTH;
	localparam int CMP_W = CNT_W + 1;
	localparam int LIM_W = (CMP_W > 6) ? CMP_W : 6;

	// One entry is {key, reference tag, x, y}.
	logic [ENT_W-1:0] mem [DEPTH];
	logic [ENT_W-1:0] rd_q;

	kpst_pkg::cmd_t      cmd_q;
	logic [31:0]         key_q;
	logic [31:0]         ref_q;
	logic signed [15:0]  x_q;
	logic signed [15:0]  y_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    pos_q;
	logic                hit_q;
	logic [CNT_W-1:0]    count_q;
	logic                done_q;
	logic                found_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic [CNT_W-1:0]    res_cnt_q;
	logic                drop_q;

	logic [CMP_W-1:0]    cnt_ext;
	logic [CMP_W-1:0]    idx_p1;
	logic [CMP_W-1:0]    idx_p2;
	logic [CMP_W-1:0]    pos_p1;
	logic [CNT_W-1:0]    count_d;
	logic [IDX_W-1:0]    push_addr;
	logic [IDX_W-1:0]    rd_addr;
	logic                rd_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [ENT_W-1:0]    wr_data;
	logic                wr_en;
	logic signed [31:0]  x_ext;
	logic signed [31:0]  y_ext;

	assign cnt_ext = CMP_W'(count_q);
	assign idx_p1  = CMP_W'(idx_q) + CMP_W'(1);
	assign idx_p2  = CMP_W'(idx_q) + CMP_W'(2);
	assign pos_p1  = CMP_W'(pos_q) + CMP_W'(1);

	// Coordinates are sign-extended and then cut to the stored width.
	assign x_ext = 32'(x_q);
	assign y_ext = 32'(y_q);

	assign push_addr = hit_q ? pos_q : IDX_W'(count_q);

	always_comb begin
		priority if (ctl.shift_next) begin
			rd_addr = IDX_W'(idx_p2);
		end else if (ctl.shift_begin) begin
			rd_addr = IDX_W'(pos_p1);
		end else if (ctl.scan_step) begin
			rd_addr = IDX_W'(idx_p1);
		end else begin
			rd_addr = '0;
		end
	end

	assign rd_en   = ctl.load | ctl.scan_step | ctl.shift_begin | ctl.shift_next;
	assign wr_en   = ctl.push_wr | ctl.shift_wr;
	assign wr_addr = ctl.shift_wr ? idx_q : push_addr;
	assign wr_data = ctl.shift_wr ? rd_q
		: {key_q, ref_q, x_ext[COORD_WIDTH-1:0], y_ext[COORD_WIDTH-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_comb begin
		priority if (ctl.cnt_clr) begin
			count_d = '0;
		end else if (ctl.cnt_inc) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.cnt_dec) begin
			count_d = count_q - CNT_W'(1);
		end else begin
			count_d = count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= kpst_pkg::cmd_t'(cmd);
			key_q <= id;
			ref_q <= ref_tag;
			x_q   <= x_pos;
			y_q   <= y_pos;
		end
		if (ctl.emit) begin
			found_q   <= hit_q;
			res_idx_q <= ctl.push_wr ? push_addr : pos_q;
			res_cnt_q <= count_d;
			drop_q    <= ctl.drop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			pos_q   <= '0;
			hit_q   <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= ctl.emit;
			count_q <= count_d;
			priority if (ctl.load) begin
				idx_q <= '0;
				pos_q <= '0;
				hit_q <= 1'b0;
			end else if (ctl.scan_hit) begin
				hit_q <= 1'b1;
				pos_q <= idx_q;
			end else if (ctl.scan_step || ctl.shift_next) begin
				idx_q <= IDX_W'(idx_p1);
			end else if (ctl.shift_begin) begin
				idx_q <= pos_q;
			end
		end
	end

	assign sts.cmd        = cmd_q;
	assign sts.count_zero = (count_q == '0);
	assign sts.match      = (rd_q[ENT_W-1 -: 32] == key_q);
	assign sts.scan_last  = (idx_p1 >= cnt_ext);
	assign sts.hit        = hit_q;
	assign sts.room       = (LIM_W'(count_q) < LIM_W'(capacity))
		&& (LIM_W'(count_q) < LIM_W'(DEPTH));
	assign sts.pull_tail  = (pos_p1 < cnt_ext);
	assign sts.shift_last = (idx_p2 >= cnt_ext);

	assign done       = done_q;
	assign found      = found_q;
	assign slot_index = res_idx_q;
	assign count      = res_cnt_q;
	assign dropped    = drop_q;

endmodule

`default_nettype wire

/* rtl/core/keyed_pointer_slot_table.sv */
// Top level of the keyed pointer slot table: register port, controller and datapath.
`default_nettype none

// A packed table of up to DEPTH slots, each holding a 32-bit id, a 32-bit reference tag and
// x/y coordinates stored in COORD_WIDTH bits. A command beat is taken at a rising edge where
// start is high and busy is low. Push updates the slot whose id matches, or appends a slot
// when the count is below both the capacity register and DEPTH, and otherwise flags the beat
// as dropped. Pull removes the matching slot and moves every later slot down one place. Find
// reports whether the id is present and where. Clear empties the table. Every command first
// scans the occupied slots from index 0 upward, one slot per cycle through the single read
// port of the slot memory, and stops at the first match. A pull then copies the later slots
// down, again one slot per cycle on the same memory. The result beat appears on found,
// slot_index, count and dropped for exactly one cycle with done high; the receiver cannot
// stall it, so it must take every beat as it comes. Busy falls in the done cycle, so the next
// command can be taken there. The capacity register (reset 16) lies at byte address 0. The
// user must write it only while no command is in flight; the block itself does not enforce
// this.
module keyed_pointer_slot_table #(
	parameter int DEPTH       = 16,
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Command channel.
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [1:0]                             cmd,
	input  wire logic [31:0]                            id,
	input  wire logic [31:0]                            ref_tag,
	input  wire logic signed [15:0]                     x_pos,
	input  wire logic signed [15:0]                     y_pos,
	// Result channel.
	output logic                                        done,
	output logic                                        found,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] slot_index,
	output logic [$clog2(DEPTH + 1)-1:0]                count,
	output logic                                        dropped,
	// Register port.
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [2:0]                             paddr,
	input  wire logic [31:0]                            pwdata,
	output logic [31:0]                                 prdata,
	output logic                                        pready
);

	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_COUNT = CNT_W + 1;

	localparam logic [4:0] CAP_RESET = 5'd16;

	kpst_pkg::ctl_t ctl;
	kpst_pkg::sts_t sts;

	logic [4:0] capacity_q;
	logic       cap_sel;

	// The low two address bits are the byte offset within the word; bit 2 is the word index.
	assign cap_sel = (paddr[2] == 1'b0);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && cap_sel) begin
			capacity_q <= pwdata[4:0];
		end
	end

	assign prdata = cap_sel ? 32'(capacity_q) : '0;

	kpst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	kpst_dpath #(
		.DEPTH       (DEPTH),
		.COORD_WIDTH (COORD_WIDTH),
		.CNT_W       (CNT_W),
		.IDX_W       (IDX_W)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.id         (id),
		.ref_tag    (ref_tag),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.capacity   (capacity_q),
		.ctl        (ctl),
		.sts        (sts),
		.done       (done),
		.found      (found),
		.slot_index (slot_index),
		.count      (count),
		.dropped    (dropped)
	);

`ifndef ASSERT_OFF
	// A result beat always closes a command that was in flight in the cycle before.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a command in flight");

	// The reported count never passes the built depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (CMP_COUNT'(count) <= CMP_COUNT'(DEPTH)))
		else $error("count beyond the table depth");

	// A dropped push is always one whose id was absent.
	a_drop_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dropped) |-> !found)
		else $error("dropped push reported a match");

	// The block only becomes busy by taking a command beat.
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command beat");
`endif

endmodule

`default_nettype wire

/* test/keyed_pointer_slot_table_tb.sv */
// Testbench for the keyed pointer slot table: directed table plus randomized command traffic.
`timescale 1ns / 100ps

module keyed_pointer_slot_table_tb;

	// The block is built with its default sizes: 16 slots and 16-bit coordinates.
	localparam int TBL_DEPTH = 16;
	localparam logic [2:0] ADDR_CAPACITY = 3'd0;

	localparam kpst_pkg::cmd_t OP_PUSH  = kpst_pkg::CMD_PUSH;
	localparam kpst_pkg::cmd_t OP_PULL  = kpst_pkg::CMD_PULL;
	localparam kpst_pkg::cmd_t OP_FIND  = kpst_pkg::CMD_FIND;
	localparam kpst_pkg::cmd_t OP_CLEAR = kpst_pkg::CMD_CLEAR;

	// One result beat as it appears on found, slot_index, count and dropped.
	typedef struct packed {
		logic       found;
		logic [3:0] slot_index;
		logic [4:0] count;
		logic       dropped;
	} outcome_t;

	// A row of the directed table is either a command beat or a capacity write.
	typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t      kind;
		kpst_pkg::cmd_t op;
		logic [31:0]    key;
		logic [31:0]    tag;
		logic [15:0]    xv;
		logic [15:0]    yv;
		logic [4:0]     cfg_val;
		logic           typed;     // want holds a hand-written result for this row
		outcome_t       want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic [31:0]        id;
	logic [31:0]        ref_tag;
	logic signed [15:0] x_pos;
	logic signed [15:0] y_pos;
	logic               done;
	logic               found;
	logic [3:0]         slot_index;
	logic [4:0]         count;
	logic               dropped;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	keyed_pointer_slot_table DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.id         (id),
		.ref_tag    (ref_tag),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.done       (done),
		.found      (found),
		.slot_index (slot_index),
		.count      (count),
		.dropped    (dropped),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Shadow copy of the table. Only the keys, the fill level and the capacity shape a result;
	// the tag and the coordinates ride along in the slots but never show up on the result port,
	// so the shadow does not keep them.
	logic [31:0] tbl_key [TBL_DEPTH];
	int          tbl_count;
	int          tbl_cap;

	// Results still owed by the block, oldest first.
	outcome_t outcome_q [$];

	int bad_beats;
	int beats_checked;
	int beats_sent;
	int hits_seen;
	int drops_seen;
	int peak_fill;
	int cap_writes;

	outcome_t seen_beat;
	outcome_t want_beat;

	// Applies one command to the shadow table and returns the result beat it must produce.
	// Every command first searches the occupied slots from index 0 upward; the first match
	// wins. A capacity above the built depth behaves as the depth.
	function automatic outcome_t apply_table_cmd(kpst_pkg::cmd_t op, logic [31:0] key);
		outcome_t o;
		int       hit_at;
		int       room;
		o = '0;
		hit_at = -1;
		for (int i = 0; i < tbl_count; i++) begin
			if (hit_at < 0 && tbl_key[i] == key) begin
				hit_at = i;
			end
		end
		room = (tbl_cap > TBL_DEPTH) ? TBL_DEPTH : tbl_cap;
		o.found = (hit_at >= 0);
		case (op)
			OP_PUSH: begin
				// An update in place is allowed even when the capacity has since been lowered
				// below the fill level; only a new key needs room.
				if (hit_at >= 0) begin
					o.slot_index = hit_at[3:0];
				end else if (tbl_count < room) begin
					tbl_key[tbl_count] = key;
					o.slot_index = tbl_count[3:0];
					tbl_count++;
				end else begin
					o.dropped = 1'b1;
				end
			end
			OP_PULL: begin
				// Compaction: every later slot moves down one place.
				if (hit_at >= 0) begin
					for (int i = hit_at; i + 1 < tbl_count; i++) begin
						tbl_key[i] = tbl_key[i + 1];
					end
					tbl_count--;
					o.slot_index = hit_at[3:0];
				end
			end
			OP_FIND: begin
				if (hit_at >= 0) begin
					o.slot_index = hit_at[3:0];
				end
			end
			default: begin
				// Clear still reports the search made before the table is emptied.
				if (hit_at >= 0) begin
					o.slot_index = hit_at[3:0];
				end
				tbl_count = 0;
			end
		endcase
		o.count = tbl_count[4:0];
		return o;
	endfunction

	function automatic stim_row_t cmd_row(kpst_pkg::cmd_t op, logic [31:0] key,
			logic [31:0] tag, logic [15:0] xv, logic [15:0] yv);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CMD;
		r.op = op;
		r.key = key;
		r.tag = tag;
		r.xv = xv;
		r.yv = yv;
		return r;
	endfunction

	function automatic stim_row_t typed_row(stim_row_t r, outcome_t w);
		r.typed = 1'b1;
		r.want = w;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [4:0] v);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.cfg_val = v;
		return r;
	endfunction

	// Presents one command beat after the given number of idle cycles and waits until the
	// block takes it. Start is left high on return, so a following beat with no gap goes out
	// back to back; the next caller decides whether to lower it.
	task automatic send_beat(input stim_row_t r, input int gap);
		outcome_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		cmd     <= r.op;
		id      <= r.key;
		ref_tag <= r.tag;
		x_pos   <= r.xv;
		y_pos   <= r.yv;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted = apply_table_cmd(r.op, r.key);
		outcome_q.push_back(r.typed ? r.want : predicted);
		beats_sent++;
		if (predicted.found) hits_seen++;
		if (predicted.dropped) drops_seen++;
		if (tbl_count > peak_fill) peak_fill = tbl_count;
	endtask

	// Holds the command channel idle until every owed result has come back. Busy falls in
	// the cycle of the last result beat, so the block is idle once this returns.
	task automatic wait_drained();
		start <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the edge that ends the
	// access cycle. Only the low five bits are the register, so the upper bits of the data
	// word carry noise.
	task automatic write_capacity(input logic [4:0] value);
		logic [31:0] noise;
		noise = $urandom();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_CAPACITY;
		pwdata  <= {noise[31:5], value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tbl_cap = value;
		cap_writes++;
	endtask

	// Result checker. The block cannot be stalled, so every cycle with done high is one beat
	// that must match the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && done) begin
			seen_beat = {found, slot_index, count, dropped};
			if (outcome_q.size() == 0) begin
				bad_beats++;
				if (bad_beats <= 10) begin
					$write("%0t: unexpected result beat found=%0b slot_index=%0d",
						$realtime, found, slot_index);
					$display(" count=%0d dropped=%0b", count, dropped);
				end
			end else begin
				want_beat = outcome_q.pop_front();
				beats_checked++;
				if (seen_beat.found !== want_beat.found ||
						seen_beat.slot_index !== want_beat.slot_index ||
						seen_beat.count !== want_beat.count ||
						seen_beat.dropped !== want_beat.dropped) begin
					bad_beats++;
					if (bad_beats <= 10) begin
						$write("%0t: result mismatch: expected found=%0b slot_index=%0d",
							$realtime, want_beat.found, want_beat.slot_index);
						$write(" count=%0d dropped=%0b,", want_beat.count,
							want_beat.dropped);
						$display(" got found=%0b slot_index=%0d count=%0d dropped=%0b",
							found, slot_index, count, dropped);
					end
				end
			end
		end
	end

	// Watchdog: far longer than the slowest correct run.
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		stim_row_t      dir_rows [$];
		stim_row_t      r;
		logic [31:0]    key_pool [24];
		logic [31:0]    key;
		int             phase_caps [8];
		int             pool_n;
		int             eff;
		int             pick;
		bit             burst;
		kpst_pkg::cmd_t op;

		arst_n  <= 1'b0;
		start   <= 1'b0;
		cmd     <= OP_FIND;
		id      <= '0;
		ref_tag <= '0;
		x_pos   <= '0;
		y_pos   <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_CAPACITY;
		pwdata  <= '0;

		tbl_count = 0;
		tbl_cap = 16;
		bad_beats = 0;
		beats_checked = 0;
		beats_sent = 0;
		hits_seen = 0;
		drops_seen = 0;
		peak_fill = 0;
		cap_writes = 0;

		// Directed part. Rows with a typed result can be read off directly; the others lean on
		// the shadow table.
		// Empty table after reset: nothing is found, nothing moves.
		dir_rows.push_back(typed_row(cmd_row(OP_FIND, 32'h0000_0000, 32'h0, 16'h0, 16'h0),
			{1'b0, 4'd0, 5'd0, 1'b0}));
		dir_rows.push_back(typed_row(cmd_row(OP_PULL, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0),
			{1'b0, 4'd0, 5'd0, 1'b0}));
		// Key, tag and coordinate extremes.
		dir_rows.push_back(typed_row(cmd_row(OP_PUSH, 32'h0000_0000, 32'h0, 16'h8000, 16'h7FFF),
			{1'b0, 4'd0, 5'd1, 1'b0}));
		dir_rows.push_back(typed_row(cmd_row(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF,
			16'h8000), {1'b0, 4'd1, 5'd2, 1'b0}));
		// Push of a present key updates in place.
		dir_rows.push_back(typed_row(cmd_row(OP_PUSH, 32'h0000_0000, 32'h5A5A_5A5A, 16'hFFFF,
			16'h0000), {1'b1, 4'd0, 5'd2, 1'b0}));
		dir_rows.push_back(typed_row(cmd_row(OP_FIND, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0),
			{1'b1, 4'd1, 5'd2, 1'b0}));
		dir_rows.push_back(cmd_row(OP_PUSH, 32'h8000_0000, 32'h8000_0001, 16'h1234, 16'hEDCB));
		dir_rows.push_back(cmd_row(OP_PUSH, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA));
		dir_rows.push_back(cmd_row(OP_PUSH, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555));
		// Pull at the head compacts the whole table; pull at the tail moves nothing.
		dir_rows.push_back(cmd_row(OP_PULL, 32'h0000_0000, 32'h0, 16'h0, 16'h0));
		dir_rows.push_back(cmd_row(OP_FIND, 32'hAAAA_AAAA, 32'h0, 16'h0, 16'h0));
		dir_rows.push_back(cmd_row(OP_PULL, 32'hAAAA_AAAA, 32'h0, 16'h0, 16'h0));
		// Pull of an absent key leaves the table alone.
		dir_rows.push_back(cmd_row(OP_PULL, 32'h0000_1234, 32'h0, 16'h0, 16'h0));
		// Clear reports the search made before it empties the table.
		dir_rows.push_back(cmd_row(OP_CLEAR, 32'h8000_0000, 32'h0, 16'h0, 16'h0));
		dir_rows.push_back(typed_row(cmd_row(OP_FIND, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0),
			{1'b0, 4'd0, 5'd0, 1'b0}));
		dir_rows.push_back(typed_row(cmd_row(OP_CLEAR, 32'h0000_0000, 32'h0, 16'h0, 16'h0),
			{1'b0, 4'd0, 5'd0, 1'b0}));
		// Capacity of one: the second new key is dropped, an update still goes through.
		dir_rows.push_back(cfg_row(5'd1));
		dir_rows.push_back(typed_row(cmd_row(OP_PUSH, 32'h0000_0011, 32'h11, 16'h11, 16'h11),
			{1'b0, 4'd0, 5'd1, 1'b0}));
		dir_rows.push_back(typed_row(cmd_row(OP_PUSH, 32'h0000_0022, 32'h22, 16'h22, 16'h22),
			{1'b0, 4'd0, 5'd1, 1'b1}));
		dir_rows.push_back(typed_row(cmd_row(OP_PUSH, 32'h0000_0011, 32'h33, 16'h33, 16'h33),
			{1'b1, 4'd0, 5'd1, 1'b0}));
		// Capacity of zero with one slot still in use: the slot stays reachable, new keys
		// have no room at all.
		dir_rows.push_back(cfg_row(5'd0));
		dir_rows.push_back(typed_row(cmd_row(OP_PUSH, 32'h0000_0033, 32'h33, 16'h33, 16'h33),
			{1'b0, 4'd0, 5'd1, 1'b1}));
		dir_rows.push_back(typed_row(cmd_row(OP_FIND, 32'h0000_0011, 32'h0, 16'h0, 16'h0),
			{1'b1, 4'd0, 5'd1, 1'b0}));
		dir_rows.push_back(typed_row(cmd_row(OP_PUSH, 32'h0000_0011, 32'h44, 16'h44, 16'h44),
			{1'b1, 4'd0, 5'd1, 1'b0}));
		dir_rows.push_back(typed_row(cmd_row(OP_PULL, 32'h0000_0011, 32'h0, 16'h0, 16'h0),
			{1'b1, 4'd0, 5'd0, 1'b0}));
		dir_rows.push_back(typed_row(cmd_row(OP_PUSH, 32'h0000_0011, 32'h55, 16'h55, 16'h55),
			{1'b0, 4'd0, 5'd0, 1'b1}));
		// Capacity above the built depth acts as the depth.
		dir_rows.push_back(cfg_row(5'd31));
		dir_rows.push_back(cmd_row(OP_PUSH, 32'h0000_0044, 32'h44, 16'h44, 16'h44));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				// Registers change only while the block is idle.
				wait_drained();
				write_capacity(dir_rows[i].cfg_val);
			end else begin
				send_beat(dir_rows[i], $urandom_range(0, 12));
			end
		end

		// Random part: one phase per capacity setting. Each phase draws a small key pool a
		// little larger than the room, so pushes, updates, drops, compaction and a full table
		// all come up often. About one key in ten is drawn fresh and will usually miss.
		phase_caps = '{16, 2, 31, 0, 7, 1, 16, 0};
		phase_caps[7] = $urandom_range(0, 31);
		for (int ph = 0; ph < 8; ph++) begin
			// The sender pauses here until everything owed has arrived.
			wait_drained();
			write_capacity(5'(phase_caps[ph]));
			eff = (phase_caps[ph] > TBL_DEPTH) ? TBL_DEPTH : phase_caps[ph];
			pool_n = eff + $urandom_range(1, 8);
			if (pool_n > 24) pool_n = 24;
			if (pool_n < 4) pool_n = 4;
			for (int k = 0; k < 24; k++) begin
				key_pool[k] = $urandom();
			end
			// Every third phase runs back to back with no idle cycles at all.
			burst = (ph % 3 == 1);
			for (int n = 0; n < 50; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) op = OP_PUSH;
				else if (pick < 70) op = OP_PULL;
				else if (pick < 96) op = OP_FIND;
				else op = OP_CLEAR;
				if ($urandom_range(0, 9) == 0) key = $urandom();
				else key = key_pool[$urandom_range(0, pool_n - 1)];
				r = cmd_row(op, key, $urandom(), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)));
				send_beat(r, burst ? 0 : $urandom_range(0, 12));
			end
		end

		// Let the last results come home, then watch a while longer for stray beats.
		wait_drained();
		repeat (40) @(posedge clk);

		$display("Sent %0d command beats over %0d capacity settings.",
			beats_sent, cap_writes + 1);
		$display("Hits %0d, dropped pushes %0d, peak fill %0d of %0d, beats checked %0d, bad %0d.",
			hits_seen, drops_seen, peak_fill, TBL_DEPTH, beats_checked, bad_beats);
		if (bad_beats == 0 && outcome_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
